// ----- design/sptf_pkg.sv -----
// Shared constants, payload types and control structs of the stereo point temporal filter.
package sptf_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int COORD_WIDTH = 24;
    localparam int FRAME_WIDTH = 32;
    localparam int THR_WIDTH   = 23;
    localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(41);

    localparam int CNT_WIDTH   = $clog2(MAX_POINTS + 1);
    localparam int IDX_WIDTH   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int POINT_WIDTH = 3 * COORD_WIDTH;
    localparam int RAM_DEPTH   = 2 << IDX_WIDTH;
    localparam int RAM_ADDR_W  = IDX_WIDTH + 1;

    typedef struct packed {
        logic signed [FRAME_WIDTH-1:0] frame_id;
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
        logic signed [COORD_WIDTH-1:0] z_coord;
        logic                          has_point;
        logic                          last_point;
    } t_in;

    typedef struct packed {
        logic                          keep;
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic signed [COORD_WIDTH-1:0] z_out;
        logic                          frame_end;
        logic [CNT_WIDTH-1:0]          kept_total;
        logic                          overflowed;
    } t_out;

    typedef struct packed {
        logic accept;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_status;

endpackage

// ----- design/sptf_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module sptf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/sptf_ctrl.sv -----
// Controller state machine that sequences accept, reference scan and result hand-off.
module sptf_ctrl import sptf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.accept  = 1'b0;
        o_cmd.finish  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.done) begin
                    if (i_status.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/sptf_datapath.sv -----
// Datapath with frame bookkeeping, ping-pong point store, distance pipeline and output register.
module sptf_datapath import sptf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [THR_WIDTH-1:0] i_cfg_wr_data,
    input  t_in                  i_in_data,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_out_valid,
    output t_out                 o_out_data,
    input  logic                 i_out_stall
);

    localparam int MAG_W = (COORD_WIDTH > THR_WIDTH) ? COORD_WIDTH : THR_WIDTH;
    localparam int SQ_W  = 2 * THR_WIDTH;
    localparam int SUM_W = SQ_W + 2;
    localparam logic [CNT_WIDTH-1:0] CNT_MAX = CNT_WIDTH'(MAX_POINTS);

    function automatic logic [MAG_W-1:0] abs_diff(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        logic [COORD_WIDTH:0] d;
        logic [COORD_WIDTH:0] m;
        d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        m = d[COORD_WIDTH] ? (~d + 1'b1) : d;
        return MAG_W'(m);
    endfunction

    logic [THR_WIDTH-1:0]   r_thr;
    logic [SQ_W-1:0]        r_thr_sq;
    logic [CNT_WIDTH-1:0]   r_ref_count;
    logic [CNT_WIDTH-1:0]   r_cur_count;
    logic [CNT_WIDTH-1:0]   r_kept;
    logic [FRAME_WIDTH-1:0] r_ref_frame;
    logic                   r_have_ref;
    logic                   r_bank;
    logic                   r_frame_open;
    logic                   r_filter_on;
    logic                   r_ovf;
    t_in                    r_item;

    logic                   r_scan;
    logic                   r_issue;
    logic                   r_found;
    logic [CNT_WIDTH-1:0]   r_rd_idx;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_v3;
    logic                   r_box2;
    logic                   r_box3;
    logic [THR_WIDTH-1:0]   r_dx;
    logic [THR_WIDTH-1:0]   r_dy;
    logic [THR_WIDTH-1:0]   r_dz;
    logic [SQ_W-1:0]        r_sqx;
    logic [SQ_W-1:0]        r_sqy;
    logic [SQ_W-1:0]        r_sqz;

    logic                   r_out_valid;
    t_out                   r_out;

    logic                   open_filter;
    logic                   eff_filter;
    logic [CNT_WIDTH-1:0]   eff_count;
    logic [CNT_WIDTH-1:0]   eff_kept;
    logic                   eff_ovf;
    logic                   store;
    logic                   need_scan;
    logic                   wr_en;
    logic [RAM_ADDR_W-1:0]  wr_addr;
    logic [RAM_ADDR_W-1:0]  rd_addr;
    logic [POINT_WIDTH-1:0] rd_data;
    logic [CNT_WIDTH-1:0]   rd_idx_inc;
    logic [MAG_W-1:0]       mag_x;
    logic [MAG_W-1:0]       mag_y;
    logic [MAG_W-1:0]       mag_z;
    logic [MAG_W-1:0]       thr_ext;
    logic                   box;
    logic [SUM_W-1:0]       sq_sum;
    logic                   hit;
    logic                   pipe_empty;
    logic                   out_free;
    logic [CNT_WIDTH-1:0]   kept_next;

    assign open_filter = r_have_ref &&
                         !($signed(i_in_data.frame_id) < $signed(r_ref_frame));
    assign eff_filter  = r_frame_open ? r_filter_on : open_filter;
    assign eff_count   = r_frame_open ? r_cur_count : '0;
    assign eff_kept    = r_frame_open ? r_kept : '0;
    assign eff_ovf     = r_frame_open ? r_ovf : 1'b0;
    assign store       = i_in_data.has_point && (eff_count < CNT_MAX);
    assign need_scan   = i_in_data.has_point && eff_filter && (r_ref_count != '0);

    assign wr_en   = i_cmd.accept && store;
    assign wr_addr = {~r_bank, eff_count[IDX_WIDTH-1:0]};
    assign rd_addr = {r_bank, r_rd_idx[IDX_WIDTH-1:0]};

    sptf_ram #(
        .WIDTH (POINT_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_in_data.x_coord, i_in_data.y_coord, i_in_data.z_coord}),
        .i_rd_en   (r_issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_idx_inc = r_rd_idx + 1'b1;

    assign mag_x = abs_diff(r_item.x_coord, rd_data[3*COORD_WIDTH-1:2*COORD_WIDTH]);
    assign mag_y = abs_diff(r_item.y_coord, rd_data[2*COORD_WIDTH-1:COORD_WIDTH]);
    assign mag_z = abs_diff(r_item.z_coord, rd_data[COORD_WIDTH-1:0]);
    assign thr_ext = MAG_W'(r_thr);
    assign box = (mag_x <= thr_ext) && (mag_y <= thr_ext) && (mag_z <= thr_ext);

    assign sq_sum = SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);
    assign hit    = r_v3 && r_box3 && (sq_sum < SUM_W'(r_thr_sq));

    assign pipe_empty = !r_v1 && !r_v2 && !r_v3;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign kept_next  = (r_found && (r_kept < CNT_MAX)) ? r_kept + 1'b1 : r_kept;

    assign o_status.done     = !r_scan;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= THR_RESET;
            r_ref_count  <= '0;
            r_cur_count  <= '0;
            r_kept       <= '0;
            r_ref_frame  <= '0;
            r_have_ref   <= 1'b0;
            r_bank       <= 1'b0;
            r_frame_open <= 1'b0;
            r_filter_on  <= 1'b0;
            r_ovf        <= 1'b0;
            r_scan       <= 1'b0;
            r_issue      <= 1'b0;
            r_found      <= 1'b0;
            r_rd_idx     <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end

            if (i_cmd.accept) begin
                r_frame_open <= 1'b1;
                if (!r_frame_open) begin
                    r_filter_on <= open_filter;
                    r_ref_frame <= i_in_data.frame_id;
                end
                r_cur_count <= store ? eff_count + 1'b1 : eff_count;
                r_ovf       <= eff_ovf || (i_in_data.has_point && !store);
                r_kept      <= eff_kept;
                r_found     <= 1'b0;
                r_scan      <= need_scan;
                r_issue     <= need_scan;
                r_rd_idx    <= '0;
                r_v1        <= 1'b0;
                r_v2        <= 1'b0;
                r_v3        <= 1'b0;
            end else if (hit) begin
                r_found <= 1'b1;
                r_scan  <= 1'b0;
                r_issue <= 1'b0;
                r_v1    <= 1'b0;
                r_v2    <= 1'b0;
                r_v3    <= 1'b0;
            end else begin
                r_v1 <= r_issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                if (r_issue) begin
                    r_rd_idx <= rd_idx_inc;
                    if (rd_idx_inc == r_ref_count) begin
                        r_issue <= 1'b0;
                    end
                end else if (r_scan && pipe_empty) begin
                    r_scan <= 1'b0;
                end
            end

            if (i_cmd.finish) begin
                r_kept      <= kept_next;
                r_out_valid <= 1'b1;
                if (r_item.last_point) begin
                    r_bank       <= ~r_bank;
                    r_ref_count  <= r_cur_count;
                    r_have_ref   <= 1'b1;
                    r_frame_open <= 1'b0;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_sq <= r_thr * r_thr;
        r_dx     <= mag_x[THR_WIDTH-1:0];
        r_dy     <= mag_y[THR_WIDTH-1:0];
        r_dz     <= mag_z[THR_WIDTH-1:0];
        r_box2   <= box;
        r_sqx    <= r_dx * r_dx;
        r_sqy    <= r_dy * r_dy;
        r_sqz    <= r_dz * r_dz;
        r_box3   <= r_box2;
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.finish) begin
            r_out.keep       <= r_found;
            r_out.x_out      <= r_item.has_point ? r_item.x_coord : '0;
            r_out.y_out      <= r_item.has_point ? r_item.y_coord : '0;
            r_out.z_out      <= r_item.has_point ? r_item.z_coord : '0;
            r_out.frame_end  <= r_item.last_point;
            r_out.kept_total <= kept_next;
            r_out.overflowed <= r_ovf;
        end
    end

endmodule

// ----- design/stereo_point_temporal_filter.sv -----
// Top level of the stereo point temporal filter: controller, datapath and port wiring.
//
// Points enter one beat at a time on the input channel (i_in_valid, o_in_stall,
// i_in_data) and are grouped into frames by last_point. Every accepted beat gives
// exactly one result beat on the output channel (o_out_valid, i_out_stall,
// o_out_data), in order. The keep threshold is written through i_cfg_wr_en and
// i_cfg_wr_data; the user must do so only while the block is idle, which the
// block itself does not enforce. An item that needs no search goes from S_IDLE
// through S_SCAN into the result register, and the next item can be accepted
// once the controller is back in S_IDLE. A point that is filtered walks the
// previous frame's stored points through the single read port of the point store,
// one per cycle, through the distance pipeline; its result is registered when the
// walk and the pipeline are through without a match, and a match at any stored
// point ends the search early. The reference frame holds at most 1024 points.
// The block takes one item at a time; o_in_stall is high while an item is at work.
// A finished result waits in the output register while the receiver stalls;
// the next item is still accepted and processed, and then waits until that
// register is free. Reset clears all frame state and sets the threshold to 41;
// the point store itself is not cleared and needs no clearing pass.
module stereo_point_temporal_filter import sptf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [THR_WIDTH-1:0] i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data
);

    t_cmd    cmd;
    t_status status;

    sptf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    sptf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule
